// ----- src/satc_pkg.sv -----
// Shared types, register indexes and the per-item micro-op program of the tone canceller.
package satc_pkg;

	// Micro-op kinds of the shared multiply-accumulate datapath
	typedef enum logic [1:0] {
		K_NOP,
		K_MAC,
		K_ADD,
		K_SQ
	} kind_t;

	// Operand sources
	typedef enum logic [4:0] {
		SRC_Z0, SRC_Z1, SRC_X0, SRC_X1, SRC_ET0, SRC_ET1, SRC_W0, SRC_W1,
		SRC_TH0, SRC_TH1, SRC_Y, SRC_C, SRC_S, SRC_AL, SRC_EPS, SRC_GA, SRC_GN,
		SRC_T, SRC_U, SRC_Z0N, SRC_X0N, SRC_X1N, SRC_E, SRC_GE, SRC_D0, SRC_D1
	} src_t;

	// Result destinations; DST_SW closes the squared-norm sum and commits the item
	typedef enum logic [3:0] {
		DST_NONE, DST_T, DST_DRV, DST_X1N, DST_U, DST_Z1N, DST_X0N, DST_W0N,
		DST_W1N, DST_Z0N, DST_E, DST_GE, DST_E0N, DST_E1N, DST_SW
	} dest_t;

	typedef struct packed {
		kind_t kind;
		src_t  a;
		src_t  b;
		logic  sub;
		logic  first;
		dest_t dest;
	} uop_t;

	localparam int PC_W = 6;
	localparam logic [PC_W-1:0] UOP_LAST = 6'd43;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic load_out;
		uop_t uop;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_status_t;

	typedef struct packed {
		logic        we;
		logic [2:0]  index;
		logic [63:0] data;
	} cfg_wr_t;

	// Register indexes
	localparam logic [2:0] REG_EPSILON  = 3'd0;
	localparam logic [2:0] REG_ALPHA    = 3'd1;
	localparam logic [2:0] REG_GAMMA    = 3'd2;
	localparam logic [2:0] REG_H_SQ     = 3'd3;
	localparam logic [2:0] REG_OUT_GAIN = 3'd4;
	localparam logic [2:0] REG_ROTATION = 3'd5;
	localparam logic [2:0] REG_THETA_A  = 3'd6;
	localparam logic [2:0] REG_THETA_B  = 3'd7;

	function automatic uop_t mk(kind_t k, src_t a, src_t b, logic sub, logic first,
		dest_t d);
		uop_t r;
		r.kind  = k;
		r.a     = a;
		r.b     = b;
		r.sub   = sub;
		r.first = first;
		r.dest  = d;
		return r;
	endfunction

	// Program of one item; a slot reads a stored result only after the accumulate stage has written it
	function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
		uop_t r;
		unique case (pc)
			6'd0:  r = mk(K_MAC, SRC_TH0, SRC_Z0, 1'b0, 1'b1, DST_NONE);
			6'd1:  r = mk(K_MAC, SRC_TH1, SRC_Z1, 1'b0, 1'b0, DST_T);
			6'd2:  r = mk(K_MAC, SRC_GN, SRC_W0, 1'b0, 1'b1, DST_DRV);
			6'd3:  r = mk(K_MAC, SRC_S, SRC_X0, 1'b0, 1'b1, DST_NONE);
			6'd4:  r = mk(K_MAC, SRC_C, SRC_X1, 1'b0, 1'b0, DST_X1N);
			6'd5:  r = mk(K_MAC, SRC_EPS, SRC_T, 1'b1, 1'b1, DST_U);
			6'd6:  r = mk(K_MAC, SRC_S, SRC_Z0, 1'b1, 1'b1, DST_NONE);
			6'd7:  r = mk(K_MAC, SRC_C, SRC_Z1, 1'b0, 1'b0, DST_NONE);
			6'd8:  r = mk(K_MAC, SRC_TH1, SRC_U, 1'b0, 1'b0, DST_Z1N);
			6'd9:  r = mk(K_MAC, SRC_C, SRC_X0, 1'b0, 1'b1, DST_NONE);
			6'd10: r = mk(K_MAC, SRC_AL, SRC_X0, 1'b1, 1'b0, DST_NONE);
			6'd11: r = mk(K_MAC, SRC_S, SRC_X1, 1'b1, 1'b0, DST_NONE);
			6'd12: r = mk(K_ADD, SRC_U, SRC_U, 1'b0, 1'b0, DST_X0N);
			6'd13: r = mk(K_MAC, SRC_C, SRC_W0, 1'b0, 1'b1, DST_NONE);
			6'd14: r = mk(K_MAC, SRC_S, SRC_W1, 1'b0, 1'b0, DST_NONE);
			6'd15: r = mk(K_ADD, SRC_U, SRC_U, 1'b0, 1'b0, DST_W0N);
			6'd16: r = mk(K_MAC, SRC_S, SRC_W0, 1'b1, 1'b1, DST_NONE);
			6'd17: r = mk(K_MAC, SRC_C, SRC_W1, 1'b0, 1'b0, DST_W1N);
			6'd18: r = mk(K_MAC, SRC_C, SRC_Z0, 1'b0, 1'b1, DST_NONE);
			6'd19: r = mk(K_MAC, SRC_S, SRC_Z1, 1'b0, 1'b0, DST_NONE);
			6'd20: r = mk(K_MAC, SRC_TH0, SRC_U, 1'b0, 1'b0, DST_NONE);
			6'd21: r = mk(K_MAC, SRC_AL, SRC_Z0, 1'b1, 1'b0, DST_NONE);
			6'd22: r = mk(K_MAC, SRC_AL, SRC_Y, 1'b0, 1'b0, DST_Z0N);
			6'd25: r = mk(K_ADD, SRC_Z0N, SRC_Z0N, 1'b0, 1'b1, DST_NONE);
			6'd26: r = mk(K_ADD, SRC_Y, SRC_Y, 1'b1, 1'b0, DST_NONE);
			6'd27: r = mk(K_MAC, SRC_TH0, SRC_X0N, 1'b1, 1'b0, DST_NONE);
			6'd28: r = mk(K_MAC, SRC_ET0, SRC_X0N, 1'b0, 1'b0, DST_NONE);
			6'd29: r = mk(K_MAC, SRC_TH1, SRC_X1N, 1'b1, 1'b0, DST_NONE);
			6'd30: r = mk(K_MAC, SRC_ET1, SRC_X1N, 1'b0, 1'b0, DST_E);
			6'd33: r = mk(K_MAC, SRC_GA, SRC_E, 1'b0, 1'b1, DST_GE);
			6'd36: r = mk(K_ADD, SRC_ET0, SRC_ET0, 1'b0, 1'b1, DST_NONE);
			6'd37: r = mk(K_MAC, SRC_X0N, SRC_GE, 1'b1, 1'b0, DST_E0N);
			6'd38: r = mk(K_ADD, SRC_ET1, SRC_ET1, 1'b0, 1'b1, DST_NONE);
			6'd39: r = mk(K_MAC, SRC_X1N, SRC_GE, 1'b1, 1'b0, DST_E1N);
			6'd42: r = mk(K_SQ, SRC_D0, SRC_D0, 1'b0, 1'b1, DST_NONE);
			6'd43: r = mk(K_SQ, SRC_D1, SRC_D1, 1'b0, 1'b0, DST_SW);
			default: r = mk(K_NOP, SRC_Z0, SRC_Z0, 1'b0, 1'b0, DST_NONE);
		endcase
		return r;
	endfunction

endpackage

// ----- src/satc_if.sv -----
// Valid/ready stream interfaces for the sample and result channels.
interface satc_in_if #(
	parameter int SAMPLE_WIDTH = 24
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] measured;

	modport source (output valid, output measured, input ready);
	modport sink (input valid, input measured, output ready);
endinterface

interface satc_out_if #(
	parameter int SAMPLE_WIDTH = 24
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] drive;
	logic                           clipped;
	logic                           switched;

	modport source (output valid, output drive, output clipped, output switched, input ready);
	modport sink (input valid, input drive, input clipped, input switched, output ready);
endinterface

// ----- src/satc_ctrl.sv -----
// Sequencer: walks the micro-op program for each item and manages the handshakes.
module satc_ctrl import satc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	state_t          state_q, state_nx;
	logic [PC_W-1:0] pc_q;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nx = ST_RUN;
			ST_RUN:    if (pc_q == UOP_LAST) state_nx = ST_DRAIN;
			ST_DRAIN:  if (status.done) state_nx = ST_FINISH;
			ST_FINISH: if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd.capture  = 1'b0;
		cmd.load_out = 1'b0;
		cmd.uop      = uop_rom('0);
		cmd.uop.kind = K_NOP;
		cmd.uop.dest = DST_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_RUN:    cmd.uop = uop_rom(pc_q);
			ST_DRAIN:  ;
			ST_FINISH: cmd.load_out = out_free;
			default:   ;
		endcase
	end

	// Advance state and program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_RUN) pc_q <= pc_q + 1'b1;
			else pc_q <= '0;
		end
	end

	// Hold the result item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/satc_dp.sv -----
// Datapath: configuration, state vectors and one shared rounding multiply-accumulate pipeline.
module satc_dp import satc_pkg::*; #(
	parameter int DATA_WIDTH   = 32,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_wr_t                        cfg,
	input  logic signed [SAMPLE_WIDTH-1:0] measured,
	input  dp_cmd_t                        cmd,
	output dp_status_t                     status,
	output logic signed [SAMPLE_WIDTH-1:0] drive,
	output logic                           clipped,
	output logic                           switched
);

	localparam int DW    = DATA_WIDTH;
	localparam int SW    = SAMPLE_WIDTH;
	localparam int FRAC  = DW - 8;
	localparam int SFRAC = SW - 1;
	localparam int PW    = 2 * DW + 2;
	localparam int AW    = DW + 4;
	localparam int SQW   = 2 * DW + 4;
	localparam int XW    = DW + SW + 48;
	localparam int RLSH  = (FRAC >= 24) ? FRAC - 24 : 0;
	localparam int RRSH  = (FRAC < 24) ? 24 - FRAC : 0;
	localparam int YLSH  = (FRAC >= SFRAC) ? FRAC - SFRAC : 0;
	localparam int YRSH  = (FRAC < SFRAC) ? SFRAC - FRAC : 0;
	localparam int DLSH  = (SFRAC >= FRAC) ? SFRAC - FRAC : 0;
	localparam int DRSH  = (SFRAC < FRAC) ? FRAC - SFRAC : 0;
	localparam int TK    = 2 * FRAC - 24;

	localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [XW-1:0] XDMAX = XW'(DMAX);
	localparam logic signed [XW-1:0] XDMIN = XW'(DMIN);
	localparam logic signed [XW-1:0] XSMAX = XW'({1'b0, {(SW-1){1'b1}}});
	localparam logic signed [XW-1:0] XSMIN = -XSMAX - XW'(1);
	localparam logic signed [AW-1:0] ADMAX = AW'(DMAX);
	localparam logic signed [AW-1:0] ADMIN = AW'(DMIN);
	localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC - 1);
	localparam logic [PW:0] LIM  = (PW+1)'(1) << (DW - 1);

	// Align a Q8.24 register to the internal format
	function automatic logic signed [DW-1:0] reg_align(input logic [31:0] v);
		logic signed [XW-1:0] t;
		t = XW'($signed(v));
		t = t <<< RLSH;
		t = t >>> RRSH;
		return t[DW-1:0];
	endfunction

	// Round a full product to nearest (ties away from zero) and saturate
	function automatic logic signed [DW-1:0] mulq(input logic signed [PW-1:0] p);
		logic signed [PW:0] pe;
		logic [PW:0]        m;
		logic [PW:0]        r;
		logic [PW:0]        nr;
		logic signed [DW-1:0] res;
		pe = (PW+1)'(p);
		m  = p[PW-1] ? $unsigned(-pe) : $unsigned(pe);
		r  = (m + HALF) >> FRAC;
		nr = (PW+1)'(0) - r;
		if (p[PW-1]) res = (r > LIM) ? DMIN : nr[DW-1:0];
		else res = (r > LIM - (PW+1)'(1)) ? DMAX : r[DW-1:0];
		return res;
	endfunction

	function automatic logic signed [DW-1:0] sat_acc(input logic signed [AW-1:0] v);
		logic signed [DW-1:0] res;
		if (v > ADMAX) res = DMAX;
		else if (v < ADMIN) res = DMIN;
		else res = v[DW-1:0];
		return res;
	endfunction

	// Configuration registers
	logic [31:0] epsilon_q, alpha_q, gamma_q, h_sq_q, gain_q, rot_c_q, rot_s_q;

	// Architectural state
	logic signed [DW-1:0] z0_q, z1_q, x0_q, x1_q, et0_q, et1_q, w0_q, w1_q, th0_q, th1_q;
	logic signed [DW-1:0] y_q;

	// Per-item intermediates
	logic signed [DW-1:0] t_q, u_q, z0n_q, z1n_q, x0n_q, x1n_q, e_q, ge_q;
	logic signed [DW-1:0] e0n_q, e1n_q, w0n_q, w1n_q, drv_q;
	logic                 sw_q;

	logic signed [DW-1:0] c_al, s_al, al_al, eps_al, ga_al, gn_al;
	logic signed [DW:0]   a_val, b_val;

	// Pipeline
	logic signed [PW-1:0] p_s1, p_s2;
	logic signed [DW:0]   raw_s1, raw_s2;
	logic signed [DW-1:0] rnd_s2;
	kind_t                kind_s1, kind_s2;
	logic                 sub_s1, sub_s2, first_s1, first_s2;
	dest_t                dest_s1, dest_s2;

	logic signed [AW-1:0] acc_q, acc_base, acc_term, acc_nx;
	logic signed [DW-1:0] acc_sat;
	logic [SQW-1:0]       sq_q, sq_nx, thr;
	logic                 commit, over;

	logic signed [XW-1:0] y_x, d_x;

	assign c_al   = reg_align(rot_c_q);
	assign s_al   = reg_align(rot_s_q);
	assign al_al  = reg_align(alpha_q);
	assign eps_al = reg_align(epsilon_q);
	assign ga_al  = reg_align(gamma_q);
	assign gn_al  = reg_align(gain_q);

	// Select an operand
	function automatic logic signed [DW:0] pick(input src_t sel);
		logic signed [DW:0] v;
		unique case (sel)
			SRC_Z0:  v = (DW+1)'(z0_q);
			SRC_Z1:  v = (DW+1)'(z1_q);
			SRC_X0:  v = (DW+1)'(x0_q);
			SRC_X1:  v = (DW+1)'(x1_q);
			SRC_ET0: v = (DW+1)'(et0_q);
			SRC_ET1: v = (DW+1)'(et1_q);
			SRC_W0:  v = (DW+1)'(w0_q);
			SRC_W1:  v = (DW+1)'(w1_q);
			SRC_TH0: v = (DW+1)'(th0_q);
			SRC_TH1: v = (DW+1)'(th1_q);
			SRC_Y:   v = (DW+1)'(y_q);
			SRC_C:   v = (DW+1)'(c_al);
			SRC_S:   v = (DW+1)'(s_al);
			SRC_AL:  v = (DW+1)'(al_al);
			SRC_EPS: v = (DW+1)'(eps_al);
			SRC_GA:  v = (DW+1)'(ga_al);
			SRC_GN:  v = (DW+1)'(gn_al);
			SRC_T:   v = (DW+1)'(t_q);
			SRC_U:   v = (DW+1)'(u_q);
			SRC_Z0N: v = (DW+1)'(z0n_q);
			SRC_X0N: v = (DW+1)'(x0n_q);
			SRC_X1N: v = (DW+1)'(x1n_q);
			SRC_E:   v = (DW+1)'(e_q);
			SRC_GE:  v = (DW+1)'(ge_q);
			SRC_D0:  v = (DW+1)'(e0n_q) - (DW+1)'(th0_q);
			SRC_D1:  v = (DW+1)'(e1n_q) - (DW+1)'(th1_q);
			default: v = '0;
		endcase
		return v;
	endfunction

	assign a_val = pick(cmd.uop.a);
	assign b_val = pick(cmd.uop.b);

	// Multiply and round stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= K_NOP;
			kind_s2 <= K_NOP;
			dest_s1 <= DST_NONE;
			dest_s2 <= DST_NONE;
		end else begin
			kind_s1 <= cmd.uop.kind;
			dest_s1 <= cmd.uop.dest;
			kind_s2 <= kind_s1;
			dest_s2 <= dest_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1     <= a_val * b_val;
		raw_s1   <= a_val;
		sub_s1   <= cmd.uop.sub;
		first_s1 <= cmd.uop.first;
		p_s2     <= p_s1;
		rnd_s2   <= mulq(p_s1);
		raw_s2   <= raw_s1;
		sub_s2   <= sub_s1;
		first_s2 <= first_s1;
	end

	// Accumulate stage
	assign acc_base = first_s2 ? '0 : acc_q;
	assign acc_term = (kind_s2 == K_ADD) ? AW'(raw_s2) : AW'(rnd_s2);
	assign acc_nx   = sub_s2 ? acc_base - acc_term : acc_base + acc_term;
	assign acc_sat  = sat_acc(acc_nx);

	assign sq_nx  = (first_s2 ? '0 : sq_q) + SQW'($unsigned(p_s2));
	assign thr    = SQW'(h_sq_q) << TK;
	assign over   = sq_nx > thr;
	assign commit = (kind_s2 == K_SQ) && (dest_s2 == DST_SW);

	assign status.done = commit;

	always_ff @(posedge clk) begin
		if (kind_s2 == K_MAC || kind_s2 == K_ADD) begin
			acc_q <= acc_nx;
			unique case (dest_s2)
				DST_T:   t_q   <= acc_sat;
				DST_DRV: drv_q <= acc_sat;
				DST_X1N: x1n_q <= acc_sat;
				DST_U:   u_q   <= acc_sat;
				DST_Z1N: z1n_q <= acc_sat;
				DST_X0N: x0n_q <= acc_sat;
				DST_W0N: w0n_q <= acc_sat;
				DST_W1N: w1n_q <= acc_sat;
				DST_Z0N: z0n_q <= acc_sat;
				DST_E:   e_q   <= acc_sat;
				DST_GE:  ge_q  <= acc_sat;
				DST_E0N: e0n_q <= acc_sat;
				DST_E1N: e1n_q <= acc_sat;
				default: ;
			endcase
		end
		if (kind_s2 == K_SQ) sq_q <= sq_nx;
		if (commit) sw_q <= over;
	end

	// Capture the sample in the internal format
	assign y_x = ((XW'(measured)) <<< YLSH) >>> YRSH;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (y_x > XDMAX) y_q <= DMAX;
			else if (y_x < XDMIN) y_q <= DMIN;
			else y_q <= y_x[DW-1:0];
		end
	end

	// Configuration writes, theta loads and end-of-item commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= '0;
			alpha_q   <= '0;
			gamma_q   <= '0;
			h_sq_q    <= '0;
			gain_q    <= 32'h0100_0000;
			rot_c_q   <= '0;
			rot_s_q   <= 32'h0100_0000;
			z0_q      <= '0;
			z1_q      <= '0;
			x0_q      <= '0;
			x1_q      <= '0;
			w0_q      <= '0;
			w1_q      <= '0;
			et0_q     <= '0;
			et1_q     <= '0;
			th0_q     <= '0;
			th1_q     <= '0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_EPSILON:  epsilon_q <= cfg.data[31:0];
				REG_ALPHA:    alpha_q   <= cfg.data[31:0];
				REG_GAMMA:    gamma_q   <= cfg.data[31:0];
				REG_H_SQ:     h_sq_q    <= cfg.data[31:0];
				REG_OUT_GAIN: gain_q    <= cfg.data[31:0];
				REG_ROTATION: begin
					rot_c_q <= cfg.data[63:32];
					rot_s_q <= cfg.data[31:0];
				end
				REG_THETA_A: begin
					et0_q <= reg_align(cfg.data[31:0]);
					th0_q <= reg_align(cfg.data[31:0]);
				end
				REG_THETA_B: begin
					et1_q <= reg_align(cfg.data[31:0]);
					th1_q <= reg_align(cfg.data[31:0]);
				end
				default: ;
			endcase
		end else if (commit) begin
			z0_q  <= z0n_q;
			z1_q  <= z1n_q;
			x0_q  <= x0n_q;
			x1_q  <= x1n_q;
			w0_q  <= w0n_q;
			w1_q  <= w1n_q;
			et0_q <= e0n_q;
			et1_q <= e1n_q;
			if (over) begin
				th0_q <= e0n_q;
				th1_q <= e1n_q;
			end
		end
	end

	// Convert the drive value and load the result item
	assign d_x = ((XW'(drv_q)) <<< DLSH) >>> DRSH;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			switched <= sw_q;
			if (d_x > XSMAX) begin
				drive   <= XSMAX[SW-1:0];
				clipped <= 1'b1;
			end else if (d_x < XSMIN) begin
				drive   <= XSMIN[SW-1:0];
				clipped <= 1'b1;
			end else begin
				drive   <= d_x[SW-1:0];
				clipped <= 1'b0;
			end
		end
	end

endmodule

// ----- src/switching_adaptive_tone_canceller.sv -----
// Switching adaptive tone canceller: top level joining the sequencer and the datapath.
//
// Usage:
//   sample : valid/ready channel carrying one measured error sample per item.
//   result : valid/ready channel carrying drive, clipped and switched per item.
//   cfg_*  : plain write port; cfg_index selects the register, cfg_data holds the
//            value (rotation uses all 64 bits). Write only while no item is in flight.
// Timing:
//   One item runs a fixed 44-slot micro-op program on a single shared multiplier
//   followed by a two-stage round/accumulate drain and a load step, after which the
//   result is valid. The block works on one item at a time; the next sample is taken
//   as soon as the program has finished and the result is parked in the output register.
// Reset: arst_n clears all state vectors, the program counter and the output valid;
//   registers return to their reset values (gain 1.0, sin 1.0, the rest zero).
// Stall: a result not taken holds in the output register; a later item may still
//   run its program and then waits until the output register is free.
module switching_adaptive_tone_canceller import satc_pkg::*; #(
	parameter int DATA_WIDTH   = 32,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	satc_in_if.sink     sample,
	satc_out_if.source  result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;
	cfg_wr_t    cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	satc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	satc_dp #(
		.DATA_WIDTH   (DATA_WIDTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.measured (sample.measured),
		.cmd      (cmd),
		.status   (status),
		.drive    (result.drive),
		.clipped  (result.clipped),
		.switched (result.switched)
	);

endmodule

// ----- test/satc_tb_if.sv -----
// Testbench-side notes: the channel interfaces themselves come from the RTL interface file.
`timescale 1ns / 1ps
package satc_tb_pkg;
	localparam int TB_LATENCY = 64;
endpackage

// ----- test/switching_adaptive_tone_canceller_tb.sv -----
// Testbench of the tone canceller: directed and random samples checked against a bit-exact predictor.
`timescale 1ns / 1ps
module switching_adaptive_tone_canceller_tb;
	import satc_pkg::*;
	import satc_tb_pkg::*;

	localparam int DW = 32;
	localparam int SW = 24;
	localparam int FR = DW - 8;

	typedef struct packed {
		logic signed [SW-1:0] drive;
		logic                 clipped;
		logic                 switched;
	} drive_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	satc_in_if #(.SAMPLE_WIDTH(SW)) sample ();
	satc_out_if #(.SAMPLE_WIDTH(SW)) result ();

	switching_adaptive_tone_canceller #(.DATA_WIDTH(DW), .SAMPLE_WIDTH(SW)) dut (
		.clk(clk), .arst_n(arst_n), .sample(sample), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state and registers, all in Q8.24 at DATA_WIDTH 32
	longint r_eps, r_al, r_ga, r_gn, r_c, r_s;
	longint unsigned r_hsq;
	longint obs[2], rgr[2], est[2], mdl[2], thp[2];

	drive_res_t pending_q[$];
	int errors;
	int results_seen;
	int switch_seen;
	int clip_seen;
	bit idle_on;
	bit hold_off;
	int hold_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint sat_dw(longint x);
		longint lim;
		lim = 64'sd1 <<< (DW - 1);
		if (x > lim - 1) return lim - 1;
		if (x < -lim) return -lim;
		return x;
	endfunction

	// Q8.24 product rounded to nearest, ties away from zero, saturated
	function automatic longint qmul(longint a, longint b);
		logic signed [127:0] p;
		logic [127:0] m;
		logic [127:0] r;
		logic [127:0] lim;
		p = 128'(signed'(a)) * 128'(signed'(b));
		m = p[127] ? -p : p;
		r = (m + (128'd1 << (FR - 1))) >> FR;
		lim = 128'd1 << (DW - 1);
		if (p[127]) begin
			if (r > lim) return -longint'(lim);
			return -longint'(r);
		end
		if (r > lim - 1) return longint'(lim - 1);
		return longint'(r);
	endfunction

	function automatic longint ashr_floor(longint x, int s);
		return x >>> s;
	endfunction

	task automatic cancel_reset_model();
		r_eps = 0; r_al = 0; r_ga = 0; r_hsq = 0; r_gn = 64'sd16777216;
		r_c = 0; r_s = 64'sd16777216;
		obs = '{0, 0}; rgr = '{0, 0}; mdl = '{0, 0};
		est = '{0, 0}; thp = '{0, 0};
	endtask

	task automatic cancel_write_model(logic [2:0] idx, logic [63:0] v);
		case (idx)
			REG_EPSILON:  r_eps = longint'(signed'(v[31:0]));
			REG_ALPHA:    r_al = longint'(signed'(v[31:0]));
			REG_GAMMA:    r_ga = longint'(signed'(v[31:0]));
			REG_H_SQ:     r_hsq = longint'(v[31:0]);
			REG_OUT_GAIN: r_gn = longint'(signed'(v[31:0]));
			REG_ROTATION: begin
				r_c = longint'(signed'(v[63:32]));
				r_s = longint'(signed'(v[31:0]));
			end
			REG_THETA_A: begin
				est[0] = longint'(signed'(v[31:0]));
				thp[0] = est[0];
			end
			REG_THETA_B: begin
				est[1] = longint'(signed'(v[31:0]));
				thp[1] = est[1];
			end
			default: ;
		endcase
	endtask

	// Advance the canceller state by one sample and return its drive item
	function automatic drive_res_t cancel_predict(logic signed [SW-1:0] meas);
		drive_res_t res;
		longint y, d, u, z0, z1, x0, x1, e, ge, e0, e1, w0, w1, olim;
		logic signed [127:0] d0w, d1w;
		logic [127:0] nrm, thr;
		y = sat_dw(longint'(meas) <<< (FR - (SW - 1)));
		olim = 64'sd1 <<< (SW - 1);
		res.clipped = 1'b0;
		d = ashr_floor(qmul(r_gn, mdl[0]), FR - (SW - 1));
		if (d > olim - 1) begin
			d = olim - 1; res.clipped = 1'b1;
		end
		if (d < -olim) begin
			d = -olim; res.clipped = 1'b1;
		end
		res.drive = d[SW-1:0];
		u = sat_dw(-qmul(r_eps, sat_dw(qmul(thp[0], obs[0]) + qmul(thp[1], obs[1]))));
		z0 = sat_dw(qmul(r_c, obs[0]) + qmul(r_s, obs[1]) + qmul(thp[0], u)
			- qmul(r_al, obs[0]) + qmul(r_al, y));
		z1 = sat_dw(-qmul(r_s, obs[0]) + qmul(r_c, obs[1]) + qmul(thp[1], u));
		x0 = sat_dw(qmul(r_c, rgr[0]) - qmul(r_al, rgr[0]) - qmul(r_s, rgr[1]) + u);
		x1 = sat_dw(qmul(r_s, rgr[0]) + qmul(r_c, rgr[1]));
		e = sat_dw(z0 - y - qmul(thp[0], x0) + qmul(est[0], x0)
			- qmul(thp[1], x1) + qmul(est[1], x1));
		ge = qmul(r_ga, e);
		e0 = sat_dw(est[0] - qmul(x0, ge));
		e1 = sat_dw(est[1] - qmul(x1, ge));
		w0 = sat_dw(qmul(r_c, mdl[0]) + qmul(r_s, mdl[1]) + u);
		w1 = sat_dw(-qmul(r_s, mdl[0]) + qmul(r_c, mdl[1]));
		// Square in 128 bits so a full-range distance cannot wrap
		d0w = 128'(signed'(e0 - thp[0]));
		d1w = 128'(signed'(e1 - thp[1]));
		nrm = $unsigned(d0w * d0w) + $unsigned(d1w * d1w);
		thr = 128'(r_hsq) << (2 * FR - 24);
		res.switched = nrm > thr;
		if (res.switched) begin
			thp[0] = e0; thp[1] = e1;
		end
		obs = '{z0, z1}; rgr = '{x0, x1}; est = '{e0, e1}; mdl = '{w0, w1};
		return res;
	endfunction

	// Offer one sample, with random idle cycles, and hold until accepted
	task automatic send_sample(logic signed [SW-1:0] meas);
		while (idle_on && $urandom_range(99) < 32) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.measured <= meas;
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		pending_q.push_back(cancel_predict(meas));
	endtask

	task automatic wait_drained();
		sample.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (TB_LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cancel_write_model(idx, v);
		@(posedge clk);
	endtask

	function automatic logic [63:0] small_q(int span);
		return 64'(signed'(32'($urandom_range(2 * span) - span)));
	endfunction

	// Write all registers; wild picks random values, else a rotation near the unit circle
	task automatic write_setting(bit wild);
		int ang;
		real c, s;
		logic [31:0] cq, sq;
		ang = $urandom_range(359);
		c = $cos(ang * 3.14159265 / 180.0) * 16777216.0 * 0.999;
		s = $sin(ang * 3.14159265 / 180.0) * 16777216.0 * 0.999;
		cq = 32'(int'(c));
		sq = 32'(int'(s));
		write_reg(REG_ROTATION, wild ? {$urandom, $urandom} : {cq, sq});
		write_reg(REG_EPSILON, wild ? 64'($urandom) : small_q(1 << 22));
		write_reg(REG_ALPHA, wild ? 64'($urandom) : small_q(1 << 22));
		write_reg(REG_GAMMA, wild ? 64'($urandom) : small_q(1 << 20));
		write_reg(REG_H_SQ, 64'($urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 16)));
		write_reg(REG_OUT_GAIN, wild ? 64'($urandom) : small_q(1 << 26));
		write_reg(REG_THETA_A, wild ? 64'($urandom) : small_q(1 << 24));
		write_reg(REG_THETA_B, wild ? 64'($urandom) : small_q(1 << 24));
	endtask

	// Result side ready: random stall, one long hold-off counted in cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (hold_off && hold_cycles < 600) begin
				hold_cycles <= hold_cycles + 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= !idle_on || ($urandom_range(99) >= 32);
			end
		end
	end

	// Compare each result item
	always @(posedge clk) begin
		drive_res_t exp_r;
		if (arst_n && result.valid && result.ready) begin
			results_seen <= results_seen + 1;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected item drive=%h", $time, result.drive);
				errors <= errors + 1;
			end else begin
				exp_r = pending_q.pop_front();
				if (exp_r.drive !== result.drive || exp_r.clipped !== result.clipped
					|| exp_r.switched !== result.switched) begin
					$display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
						exp_r.drive, exp_r.clipped, exp_r.switched,
						result.drive, result.clipped, result.switched);
					errors <= errors + 1;
				end
				if (result.switched) switch_seen <= switch_seen + 1;
				if (result.clipped) clip_seen <= clip_seen + 1;
			end
		end
	end

	task automatic test_directed();
		logic signed [SW-1:0] edges[6];
		edges = '{24'sh7fffff, -24'sh800000, 24'sh0, 24'sh1, -24'sh1, 24'sh555555};
		foreach (edges[i]) send_sample(edges[i]);
		wait_drained();
		write_reg(REG_OUT_GAIN, 64'h7fffffff);
		write_reg(REG_EPSILON, 64'h80000000);
		write_reg(REG_ALPHA, 64'h7fffffff);
		write_reg(REG_GAMMA, 64'h7fffffff);
		write_reg(REG_H_SQ, 64'h0);
		write_reg(REG_ROTATION, 64'h7fffffff_80000000);
		write_reg(REG_THETA_A, 64'h7fffffff);
		write_reg(REG_THETA_B, 64'h80000000);
		foreach (edges[i]) send_sample(edges[i]);
		wait_drained();
		write_reg(REG_H_SQ, 64'hffffffff);
		write_reg(REG_OUT_GAIN, 64'h80000000);
		write_reg(REG_ROTATION, 64'h01000000_00000000);
		for (int i = 0; i < 6; i++) send_sample(edges[i]);
		wait_drained();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 18; ph++) begin
			write_setting(ph % 6 == 5);
			idle_on = (ph != 3);
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(9) == 0) send_sample(SW'($urandom));
				else send_sample(SW'(signed'(32'($urandom_range(1 << 20)) - (1 << 19))));
			end
			wait_drained();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int i = 0; i < 40; i++) send_sample(SW'($urandom));
		wait_drained();
		hold_off = 1'b0;
	endtask

	initial begin
		errors = 0; results_seen = 0; switch_seen = 0; clip_seen = 0;
		idle_on = 1'b1; hold_off = 1'b0;
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.measured = '0;
		cfg_we = 1'b0;
		cfg_index = REG_EPSILON;
		cfg_data = '0;
		cancel_reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		$display("Covered %0d items over directed corner settings and 18 random settings,",
			results_seen);
		$display("with %0d switches and %0d clipped drive values.", switch_seen, clip_seen);
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
